FILE: sv/radix2_complex_fft_unit_macros.svh
// ---------------------------------------------------------------------------
// radix2_complex_fft_unit assertion macros
// Short forms for the concurrent checks of the FFT unit.
// ---------------------------------------------------------------------------
`ifndef RADIX2_COMPLEX_FFT_UNIT_MACROS_SVH
`define RADIX2_COMPLEX_FFT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define R2F_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2fft same-cycle check failed");

// next-cycle implication, disabled in reset
`define R2F_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r2fft next-cycle check failed");

`endif

FILE: sv/r2fft_pkg.sv
// ---------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, register indexes and the twiddle sine table.
// ---------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

  localparam int DEF_POINTS     = 64;
  localparam int DEF_WORK_WIDTH = 24;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 24;
  localparam int TW_W           = 16;
  localparam int CFG_W          = 3;
  localparam int IDX_W          = 1;

  localparam logic [IDX_W-1:0] REG_SIZE_LOG2 = 1'b0;
  localparam logic [IDX_W-1:0] REG_INVERSE   = 1'b1;

  // quarter-wave table, Q1.15, +1.0 clipped to 32767
  function automatic logic signed [TW_W-1:0] quarter_sine(input logic [4:0] i);
    logic signed [TW_W-1:0] v;
    case (i)
      5'd0:    v = 16'sd0;
      5'd1:    v = 16'sd3212;
      5'd2:    v = 16'sd6393;
      5'd3:    v = 16'sd9512;
      5'd4:    v = 16'sd12540;
      5'd5:    v = 16'sd15447;
      5'd6:    v = 16'sd18205;
      5'd7:    v = 16'sd20788;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd25330;
      5'd10:   v = 16'sd27246;
      5'd11:   v = 16'sd28899;
      5'd12:   v = 16'sd30274;
      5'd13:   v = 16'sd31357;
      5'd14:   v = 16'sd32138;
      5'd15:   v = 16'sd32610;
      default: v = 16'sd32767;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] rom_sine(input logic [5:0] m);
    logic signed [TW_W-1:0] v;
    if (m <= 6'd16)      v = quarter_sine(5'(m));
    else if (m <= 6'd32) v = quarter_sine(5'(6'd32 - m));
    else if (m <= 6'd48) v = -quarter_sine(5'(m - 6'd32));
    else                 v = -quarter_sine(5'(7'd64 - {1'b0, m}));
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/r2fft_ram.sv
// ---------------------------------------------------------------------------
// r2fft_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: sv/r2fft_bfly.sv
// ---------------------------------------------------------------------------
// r2fft_bfly
// Two-stage butterfly: twiddle products, then rounding, sum/diff, saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module r2fft_bfly #(
  parameter int WW = 24
) (
  input  wire logic                                clk,
  input  wire logic signed [WW-1:0]                a_re,
  input  wire logic signed [WW-1:0]                a_im,
  input  wire logic signed [WW-1:0]                b_re,
  input  wire logic signed [WW-1:0]                b_im,
  input  wire logic signed [r2fft_pkg::TW_W-1:0]   w_re,
  input  wire logic signed [r2fft_pkg::TW_W-1:0]   w_im,
  output logic      signed [WW-1:0]                sum_re,
  output logic      signed [WW-1:0]                sum_im,
  output logic      signed [WW-1:0]                dif_re,
  output logic      signed [WW-1:0]                dif_im
);
  import r2fft_pkg::*;

  localparam int PW = WW + TW_W;
  localparam int SW = PW + 2;
  localparam int TW = SW - 15;
  localparam int RW = TW + 1;
  localparam logic signed [RW-1:0] SMAX = RW'({(WW-1){1'b1}});
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [WW-1:0] ah_re, ah_im;
  logic signed [SW-1:0] acc_re, acc_im;
  logic signed [TW-1:0] t_re, t_im;
  logic signed [RW-1:0] s_re, s_im, d_re, d_im;

  function automatic logic signed [WW-1:0] sat_w(input logic signed [RW-1:0] v);
    if (v > SMAX) return WW'(SMAX);
    if (v < SMIN) return WW'(SMIN);
    return WW'(v);
  endfunction

  always_ff @(posedge clk) begin
    p_rr  <= PW'(b_re) * PW'(w_re);
    p_ii  <= PW'(b_im) * PW'(w_im);
    p_ri  <= PW'(b_im) * PW'(w_re);
    p_ir  <= PW'(b_re) * PW'(w_im);
    ah_re <= a_re;
    ah_im <= a_im;
  end

  // round half up then floor shift by 15
  assign acc_re = SW'(p_rr) - SW'(p_ii) + SW'(1 <<< 14);
  assign acc_im = SW'(p_ri) + SW'(p_ir) + SW'(1 <<< 14);
  assign t_re   = TW'(acc_re >>> 15);
  assign t_im   = TW'(acc_im >>> 15);
  assign s_re   = RW'(ah_re) + RW'(t_re);
  assign s_im   = RW'(ah_im) + RW'(t_im);
  assign d_re   = RW'(ah_re) - RW'(t_re);
  assign d_im   = RW'(ah_im) - RW'(t_im);

  always_ff @(posedge clk) begin
    sum_re <= sat_w(s_re);
    sum_im <= sat_w(s_im);
    dif_re <= sat_w(d_re);
    dif_im <= sat_w(d_im);
  end

endmodule

`default_nettype wire

FILE: sv/radix2_complex_fft_unit.sv
// ---------------------------------------------------------------------------
// radix2_complex_fft_unit
// In-place radix-2 DIT complex FFT/IFFT over a shared butterfly and one RAM.
// ---------------------------------------------------------------------------
//  port group | dir | handshake           | payload
//  in         | in  | in_valid/in_stall   | sample_real, sample_imag
//  out        | out | out_valid/out_stall | bin_real, bin_imag, last_bin
//  cfg        | in  | cfg_write           | cfg_index, cfg_data
//
// Load: one sample per cycle. Transform: per butterfly a RAM read, multiply,
// add and two writes through the single write port, (N/2)*log2(N)
// butterflies. Emit: one bin at a time, each held while out_stall is high.
// Synchronous reset; the RAM is not cleared. in_stall is high outside loading.
// ---------------------------------------------------------------------------
`default_nettype none
`include "radix2_complex_fft_unit_macros.svh"

module radix2_complex_fft_unit #(
  parameter int POINTS     = r2fft_pkg::DEF_POINTS,
  parameter int WORK_WIDTH = r2fft_pkg::DEF_WORK_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [r2fft_pkg::IN_W-1:0]   sample_real,
  input  wire logic signed [r2fft_pkg::IN_W-1:0]   sample_imag,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      signed [r2fft_pkg::OUT_W-1:0]  bin_real,
  output logic      signed [r2fft_pkg::OUT_W-1:0]  bin_imag,
  output logic                                     last_bin,
  input  wire logic                                cfg_write,
  input  wire logic [r2fft_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [r2fft_pkg::CFG_W-1:0]         cfg_data
);
  import r2fft_pkg::*;

  localparam int WW   = WORK_WIDTH;
  localparam int AW   = $clog2(POINTS);
  localparam int EW   = (WW + 1 > OUT_W + 1) ? WW + 1 : OUT_W + 1;
  localparam logic [2:0] MAXB = 3'(AW);
  localparam logic signed [EW-1:0] OMAX = EW'({(OUT_W-1){1'b1}});
  localparam logic signed [EW-1:0] OMIN = ~OMAX;

  typedef enum logic [3:0] {
    ST_LOAD, BF_RD, BF_MUL, BF_SUM, BF_WA, BF_WB, EM_RD, EM_DAT, EM_OUT
  } state_t;

  state_t        state;
  logic [2:0]    size_log2;
  logic          inverse_mode;
  logic [AW-1:0] load_count, j, k;
  logic [2:0]    stage, bits;
  logic [AW-1:0] last_idx, last_j, hmask, addr_a, addr_b, rev, slot;
  logic [5:0]    tw_idx;
  logic signed [TW_W-1:0] w_re, w_im;

  logic              we;
  logic [AW-1:0]     waddr, raddr_a;
  logic [2*WW-1:0]   wdata, rdata_a, rdata_b;
  logic signed [WW-1:0] sum_re, sum_im, dif_re, dif_im;
  logic              in_take;

  // clamped transform length
  always_comb begin
    if (size_log2 < 3'd1)      bits = 3'd1;
    else if (size_log2 > MAXB) bits = MAXB;
    else                       bits = size_log2;
  end

  assign last_idx = {AW{1'b1}} >> (3'(AW) - bits);
  assign last_j   = last_idx >> 1;
  assign hmask    = ~({AW{1'b1}} << (stage - 3'd1));
  assign addr_a   = ((j >> (stage - 3'd1)) << stage) | (j & hmask);
  assign addr_b   = addr_a | (AW'(1) << (stage - 3'd1));
  assign tw_idx   = 6'(6'(j & hmask) << (3'd6 - stage));

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev[i] = load_count[AW-1-i];
    end
  end
  assign slot = rev >> (3'(AW) - bits);

  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    we      = 1'b0;
    waddr   = slot;
    wdata   = {WW'(sample_real), WW'(sample_imag)};
    raddr_a = addr_a;
    unique case (state)
      ST_LOAD: we = in_take;
      BF_WA: begin
        we    = 1'b1;
        waddr = addr_a;
        wdata = {sum_re, sum_im};
      end
      BF_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = {dif_re, dif_im};
      end
      EM_RD, EM_DAT, EM_OUT: raddr_a = k;
      default: ;
    endcase
  end

  function automatic logic signed [OUT_W-1:0] emit_scale(
    input logic signed [WW-1:0] x, input logic inv, input logic [2:0] sh);
    logic signed [EW-1:0] v;
    v = EW'(x);
    if (inv) begin
      v = (v + (EW'(1) <<< (sh - 3'd1))) >>> sh;
    end
    if (v > OMAX) return OUT_W'(OMAX);
    if (v < OMIN) return OUT_W'(OMIN);
    return OUT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2    <= 3'd6;
      inverse_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SIZE_LOG2: size_log2    <= cfg_data;
        REG_INVERSE:   inverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      stage      <= 3'd1;
      j          <= '0;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (cfg_write && cfg_index == REG_SIZE_LOG2) begin
            load_count <= '0;
          end else if (in_take) begin
            if (load_count == last_idx) begin
              load_count <= '0;
              stage      <= 3'd1;
              j          <= '0;
              state      <= BF_RD;
            end else begin
              load_count <= load_count + AW'(1);
            end
          end
        end
        BF_RD: begin
          w_re  <= rom_sine(tw_idx + 6'd16);
          w_im  <= inverse_mode ? rom_sine(tw_idx) : -rom_sine(tw_idx);
          state <= BF_MUL;
        end
        BF_MUL: state <= BF_SUM;
        BF_SUM: state <= BF_WA;
        BF_WA:  state <= BF_WB;
        BF_WB: begin
          if (j == last_j) begin
            j <= '0;
            if (stage == bits) begin
              k     <= '0;
              state <= EM_RD;
            end else begin
              stage <= stage + 3'd1;
              state <= BF_RD;
            end
          end else begin
            j     <= j + AW'(1);
            state <= BF_RD;
          end
        end
        EM_RD: state <= EM_DAT;
        EM_DAT: begin
          bin_real  <= emit_scale(rdata_a[2*WW-1:WW], inverse_mode, bits);
          bin_imag  <= emit_scale(rdata_a[WW-1:0], inverse_mode, bits);
          last_bin  <= (k == last_idx);
          out_valid <= 1'b1;
          state     <= EM_OUT;
        end
        EM_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (k == last_idx) begin
              state <= ST_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= EM_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  r2fft_ram #(
    .WIDTH (2 * WW),
    .DEPTH (POINTS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (addr_b),
    .rdata_b (rdata_b)
  );

  r2fft_bfly #(
    .WW (WW)
  ) u_bfly (
    .clk    (clk),
    .a_re   (rdata_a[2*WW-1:WW]),
    .a_im   (rdata_a[WW-1:0]),
    .b_re   (rdata_b[2*WW-1:WW]),
    .b_im   (rdata_b[WW-1:0]),
    .w_re   (w_re),
    .w_im   (w_im),
    .sum_re (sum_re),
    .sum_im (sum_im),
    .dif_re (dif_re),
    .dif_im (dif_im)
  );

  `R2F_ASSERT_NOW(a_valid_only_emit, clk, rst, out_valid, state == EM_OUT)
  `R2F_ASSERT_NOW(a_no_write_emit, clk, rst, state == EM_RD || state == EM_DAT || state == EM_OUT, !we)
  `R2F_ASSERT_NEXT(a_last_load_runs, clk, rst, in_take && load_count == last_idx && !cfg_write, state == BF_RD)
  `R2F_ASSERT_NOW(a_stage_range, clk, rst, state == BF_RD, stage >= 3'd1 && stage <= bits)

endmodule

`default_nettype wire

FILE: test/radix2_complex_fft_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix2_complex_fft_unit_test
// Self-checking bench for the radix-2 FFT unit: a directed table of frames and
// register writes, then random frames of random length and direction, each bin
// compared with a bit-exact software transform held in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module radix2_complex_fft_unit_test;
  import r2fft_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE         = 20;
  localparam int LONG_HOLD      = 300;

  typedef enum {ROW_SAMPLE, ROW_TYPED, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t kind;
    int        a, b, c, d;
  } row_t;

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    bit                      last;
  } bin_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [IN_W-1:0]  sample_real = '0;
  logic signed [IN_W-1:0]  sample_imag = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b1;
  logic signed [OUT_W-1:0] bin_real;
  logic signed [OUT_W-1:0] bin_imag;
  logic                    last_bin;
  logic                    cfg_write = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  // typed expectation travels with the word that completes a frame
  logic                    typed_frame = 1'b0;
  logic signed [OUT_W-1:0] typed_re = '0;
  logic signed [OUT_W-1:0] typed_im = '0;

  bit quiet     = 1'b0;
  bit hold_long = 1'b0;

  bin_t bin_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   words_in = 0;
  int   bins_out = 0;
  int   frames_done = 0;

  // bench copy of the transform state
  longint  st_re[64];
  longint  st_im[64];
  int      ld_count;
  int      m_size;
  bit      m_inv;

  radix2_complex_fft_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_real(sample_real), .sample_imag(sample_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_real(bin_real), .bin_imag(bin_imag), .last_bin(last_bin),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint twiddle_sine(int m);
    int q[17];
    q = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
          25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
    m = m & 63;
    if (m <= 16) return q[m];
    if (m <= 32) return q[32 - m];
    if (m <= 48) return -q[m - 32];
    return -q[64 - m];
  endfunction

  function automatic int reverse_bits(int v, int bits);
    int r;
    r = 0;
    for (int i = 0; i < bits; i++) begin
      r = (r << 1) | (v & 1);
      v = v >> 1;
    end
    return r;
  endfunction

  task automatic take_sample(longint re, longint im);
    int     bits, n, slot, a, b, m;
    longint wr, wi, br, bi, tr, ti, ar, ai, vr, vi;
    bin_t   e;
    bits = (m_size < 1) ? 1 : (m_size > 6) ? 6 : m_size;
    n = 1 << bits;
    if (ld_count >= n) ld_count = 0;
    slot = reverse_bits(ld_count, bits);
    st_re[slot] = re;
    st_im[slot] = im;
    if (ld_count + 1 < n) begin
      ld_count++;
      return;
    end
    ld_count = 0;
    for (int s = 1; s <= bits; s++)
      for (int base = 0; base < n; base += (1 << s))
        for (int k = 0; k < (1 << (s - 1)); k++) begin
          a = base + k;
          b = a + (1 << (s - 1));
          m = k << (6 - s);
          wr = twiddle_sine(m + 16);
          wi = m_inv ? twiddle_sine(m) : -twiddle_sine(m);
          br = st_re[b]; bi = st_im[b];
          tr = round_down(wr * br - wi * bi, 15);
          ti = round_down(wr * bi + wi * br, 15);
          ar = st_re[a]; ai = st_im[a];
          st_re[b] = clip(ar - tr, 24);
          st_im[b] = clip(ai - ti, 24);
          st_re[a] = clip(ar + tr, 24);
          st_im[a] = clip(ai + ti, 24);
        end
    for (int k = 0; k < n; k++) begin
      vr = st_re[k];
      vi = st_im[k];
      if (m_inv) begin
        vr = round_down(vr, bits);
        vi = round_down(vi, bits);
      end
      e.re = typed_frame ? typed_re : OUT_W'(clip(vr, 24));
      e.im = typed_frame ? typed_im : OUT_W'(clip(vi, 24));
      e.last = (k == n - 1);
      bin_q.push_back(e);
    end
  endtask

  // scoreboard, register shadow and watchdog
  always @(posedge clk) begin
    bin_t e;
    bit   moved;
    if (rst) begin
      ld_count = 0;
      m_size = 6;
      m_inv = 1'b0;
      for (int i = 0; i < 64; i++) begin
        st_re[i] = 0;
        st_im[i] = 0;
      end
    end else begin
      moved = 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_SIZE_LOG2) begin
          m_size = cfg_data;
          ld_count = 0;
        end else if (cfg_index == REG_INVERSE) begin
          m_inv = cfg_data[0];
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        words_in <= words_in + 1;
        take_sample(sample_real, sample_imag);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        bins_out <= bins_out + 1;
        if (bin_q.size() == 0) begin
          $error("bin with nothing expected: re %0d im %0d", bin_real, bin_imag);
          errors++;
        end else begin
          e = bin_q.pop_front();
          if (bin_real !== e.re) begin
            $error("bin_real expected %0d got %0d", e.re, bin_real);
            errors++;
          end
          if (bin_imag !== e.im) begin
            $error("bin_imag expected %0d got %0d", e.im, bin_imag);
            errors++;
          end
          if (last_bin !== e.last) begin
            $error("last_bin expected %0d got %0d", e.last, last_bin);
            errors++;
          end
          if (e.last) frames_done <= frames_done + 1;
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d bins outstanding", bin_q.size());
        $display("radix2_complex_fft_unit_test: errors");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end
      w = quiet ? 0 : $urandom_range(0, 4);
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(int re, int im, bit typed = 0, int tre = 0, int tim = 0);
    int w;
    w = quiet ? 0 : $urandom_range(0, 4);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_real <= IN_W'(re);
    sample_imag <= IN_W'(im);
    typed_frame <= typed;
    typed_re <= OUT_W'(tre);
    typed_im <= OUT_W'(tim);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bin_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  row_t dir_rows[] = '{
    '{ROW_CFG, REG_SIZE_LOG2, 1, 0, 0},
    '{ROW_CFG, REG_INVERSE, 0, 0, 0},
    // impulse at the first sample: every bin equals it
    '{ROW_SAMPLE, 32767, -32768, 0, 0},
    '{ROW_TYPED, 0, 0, 32767, -32768},
    '{ROW_SAMPLE, -32768, 32767, 0, 0},
    '{ROW_SAMPLE, -32768, 32767, 0, 0},
    '{ROW_SAMPLE, -32768, -32768, 0, 0},
    '{ROW_SAMPLE, 32767, 32767, 0, 0},
    '{ROW_CFG, REG_INVERSE, 1, 0, 0},
    '{ROW_SAMPLE, 32767, 32767, 0, 0},
    '{ROW_SAMPLE, -32768, -32768, 0, 0},
    // length below range is taken as two points
    '{ROW_CFG, REG_SIZE_LOG2, 0, 0, 0},
    '{ROW_SAMPLE, -32768, 1, 0, 0},
    '{ROW_SAMPLE, 32767, -1, 0, 0},
    '{ROW_CFG, REG_SIZE_LOG2, 2, 0, 0},
    '{ROW_CFG, REG_INVERSE, 0, 0, 0},
    '{ROW_SAMPLE, 32767, -32768, 0, 0},
    '{ROW_SAMPLE, -32768, 32767, 0, 0},
    '{ROW_SAMPLE, 32767, 32767, 0, 0},
    '{ROW_SAMPLE, -32768, -32768, 0, 0},
    // partial frame dropped by a length write
    '{ROW_SAMPLE, 1234, -4321, 0, 0},
    '{ROW_SAMPLE, -77, 99, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0, 0},
    '{ROW_CFG, REG_SIZE_LOG2, 2, 0, 0},
    '{ROW_SAMPLE, 100, 200, 0, 0},
    '{ROW_SAMPLE, -300, 400, 0, 0},
    '{ROW_SAMPLE, 500, -600, 0, 0},
    '{ROW_SAMPLE, -700, -800, 0, 0},
    // direction flip mid-frame, sampled when the transform runs
    '{ROW_CFG, REG_SIZE_LOG2, 2, 0, 0},
    '{ROW_SAMPLE, 30000, -20000, 0, 0},
    '{ROW_SAMPLE, -10000, 5000, 0, 0},
    '{ROW_CFG, REG_INVERSE, 1, 0, 0},
    '{ROW_SAMPLE, 25000, 15000, 0, 0},
    '{ROW_SAMPLE, -32768, 32767, 0, 0}
  };

  initial begin
    int size, n, cut, big;
    bit broken, held, press;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(IDX_W'(dir_rows[i].a), dir_rows[i].b);
        end
        ROW_TYPED:
          send_word(dir_rows[i].a, dir_rows[i].b, 1'b1, dir_rows[i].c, dir_rows[i].d);
        default:
          send_word(dir_rows[i].a, dir_rows[i].b);
      endcase
    end
    drain();
    typed_frame <= 1'b0;

    big = 0;
    held = 1'b0;
    while (words_in < 130) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (big < 2 && words_in > 60 && $urandom_range(0, 3) == 0) begin
        size = big == 0 ? 6 : 7;
        big++;
      end else begin
        size = $urandom_range(0, 5);
      end
      drain();
      write_reg(REG_SIZE_LOG2, size);
      write_reg(REG_INVERSE, $urandom_range(0, 1));
      n = 1 << ((size < 1) ? 1 : (size > 6) ? 6 : size);
      broken = ($urandom_range(0, 7) == 0);
      cut = broken ? $urandom_range(1, n - 1) : n;
      // one frame under a long receiver hold-off while words keep coming
      press = 1'b0;
      if (!held && !broken && frames_done > 8 && size <= 4) begin
        hold_long = 1'b1;
        held = 1'b1;
        press = 1'b1;
      end
      for (int k = 0; k < cut; k++)
        send_word(pick_value(), pick_value());
      // two more back-to-back frames without waiting for their bins
      if (!broken && (press || $urandom_range(0, 2) == 0))
        for (int k = 0; k < 2 * n; k++)
          send_word(pick_value(), pick_value());
    end
    drain();

    $display("%0d samples loaded, %0d bins checked over %0d frames",
             words_in, bins_out, frames_done);
    $display("lengths 2 to 64 incl. clamped settings, both directions, dropped frames");
    if (errors == 0) begin
      $display("radix2_complex_fft_unit_test: clean");
    end else begin
      $display("radix2_complex_fft_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
